// ===== sv/vbipk_pkg.sv =====
// Shared types, constants and a helper function of the VBI sliced data unit packer.
// No dependencies; every other file of the block imports this package.
package vbipk_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_DATA_ID = 2'd0;
    localparam logic [1:0] REG_SVC_EN  = 2'd1;
    localparam logic [1:0] REG_PKT_LEN = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  DATA_ID_RESET = 8'h10;
    localparam logic [6:0]  SVC_EN_RESET  = 7'h7F;
    localparam logic [15:0] PKT_LEN_RESET = 16'd184;

    // Service kind codes; the last code has no service behind it
    localparam logic [2:0] KIND_TTX    = 3'd0;
    localparam logic [2:0] KIND_VPS    = 3'd1;
    localparam logic [2:0] KIND_VPS_F2 = 3'd2;
    localparam logic [2:0] KIND_WSS    = 3'd3;
    localparam logic [2:0] KIND_CC625  = 3'd4;
    localparam logic [2:0] KIND_CC525  = 3'd5;
    localparam logic [2:0] KIND_CPR    = 3'd6;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    // Data unit ids
    localparam logic [7:0] UID_TTX   = 8'h02;
    localparam logic [7:0] UID_VPS   = 8'hC3;
    localparam logic [7:0] UID_WSS   = 8'hC4;
    localparam logic [7:0] UID_CC625 = 8'hC5;
    localparam logic [7:0] UID_CC525 = 8'hB5;
    localparam logic [7:0] UID_CPR   = 8'hB4;

    // Result status codes
    localparam logic [2:0] ST_PACKED   = 3'd0;
    localparam logic [2:0] ST_DISABLED = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_VPS_AMB  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_UNSORTED = 3'd5;
    localparam logic [2:0] ST_FLUSHED  = 3'd6;

    // Unit geometry and framing constants
    localparam logic [5:0] LEN_TTX   = 6'd46;
    localparam logic [5:0] LEN_VPS   = 6'd16;
    localparam logic [5:0] LEN_SHORT = 6'd5;
    localparam logic [5:0] LEN_CPR   = 6'd6;
    localparam logic [5:0] LEN_FIXED = 6'd46;
    localparam logic [9:0] FIELD2_625 = 10'd313;
    localparam logic [9:0] FIELD2_525 = 10'd263;
    localparam logic [7:0] TTX_FRAMING = 8'hE4;
    localparam logic [7:0] STUFF_BYTE  = 8'hFF;
    localparam int         PAY_BYTES   = 42;

    // Input request: one sliced line or a flush
    typedef struct packed {
        logic        mode;
        logic [2:0]  service_kind;
        logic [9:0]  line_number;
        logic [55:0] payload_0;
        logic [55:0] payload_1;
        logic [55:0] payload_2;
        logic [55:0] payload_3;
        logic [55:0] payload_4;
        logic [55:0] payload_5;
    } in_req_t;

    // Output request: one packet byte, one stuffing run or one skip notice
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  out_byte;
        logic [15:0] stuffing_run;
        logic [2:0]  status;
        logic        packet_end;
        logic        last;
    } out_req_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic load;
    } vbipk_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic res_last;
    } vbipk_stat_t;

    // Reverse the bit order of one byte
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7 - k] = v[k];
        end
        return r;
    endfunction

endpackage

// ===== sv/vbi_sliced_data_unit_packer.sv =====
// Top level of the VBI sliced data unit packer: controller plus datapath.
// Depends on vbipk_pkg, vbipk_ctrl and vbipk_dp.

// Each request carries one sliced VBI line (or a flush) and yields one data
// unit emitted one byte per output request, or a single stuffing or skip
// notice. An item is captured, then evaluated, then its results are loaded
// into the single output register one per cycle while the output is not
// stalled: one result for a skipped line, stuffing run or flush, and up to 46
// for a 46-byte unit. A new item is taken once the last result of the
// previous one has entered the output register. Configuration writes are
// taken only between items.
module vbi_sliced_data_unit_packer
    import vbipk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_req_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_req_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    vbipk_cmd_t  cmd;
    vbipk_stat_t stat;

    // Sequencing
    vbipk_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Checks, unit assembly and output stage
    vbipk_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/vbipk_ctrl.sv =====
// Controller of the VBI sliced data unit packer: capture, evaluate, emit sequence.
// Depends on vbipk_pkg for the command and status structs.
module vbipk_ctrl
    import vbipk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        cfg_ready,
    output vbipk_cmd_t  cmd,
    input  vbipk_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Handshake and command decode
    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        cfg_ready   = (state_reg == S_IDLE);
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.eval    = (state_reg == S_EVAL);
        cmd.load    = (state_reg == S_EMIT) && stat.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free && stat.res_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/vbipk_dp.sv =====
// Datapath of the VBI sliced data unit packer: registers, line checks, unit bytes, output stage.
// Depends on vbipk_pkg for types, constants and the bit reversal function.
module vbipk_dp
    import vbipk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_req_t     in_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  vbipk_cmd_t  cmd,
    output vbipk_stat_t stat,
    output logic        out_valid,
    input  logic        out_stall,
    output out_req_t    out_data
);

    // Configuration and persistent state
    logic [7:0]  data_id_reg;
    logic [6:0]  svc_en_reg;
    logic [15:0] pkt_len_reg;
    logic [15:0] bytes_left_reg;
    logic [9:0]  prev_line_reg;

    // Captured request and evaluation results
    in_req_t     item_reg;
    logic        single_reg;
    logic        stuff_reg;
    logic [2:0]  status_reg;
    logic [15:0] run_reg;
    logic [5:0]  len_reg;
    logic [5:0]  nat_reg;
    logic [7:0]  lofp_reg;
    logic        pend_reg;
    logic [5:0]  idx_reg;

    // Output stage
    logic        out_valid_reg;
    out_req_t    out_data_reg;

    // Evaluation signals
    logic [15:0] psize;
    logic [2:0]  kind;
    logic [9:0]  line;
    logic        fixed_len;
    logic [5:0]  nat_len;
    logic [5:0]  unit_len;
    logic [9:0]  f2;
    logic [9:0]  f2_diff;
    logic        in_f1;
    logic        in_f2;
    logic        enabled;
    logic [15:0] left_after;

    // Emission signals
    logic [335:0] pay_flat;
    logic [5:0]   pay_idx;
    logic [7:0]   pay_byte;
    logic [7:0]   unit_byte;
    logic         res_last;
    out_req_t     res;

    // Decode of the captured line
    always_comb
    begin
        psize     = (pkt_len_reg == 16'd0) ? 16'd1 : pkt_len_reg;
        kind      = item_reg.service_kind;
        line      = item_reg.line_number;
        fixed_len = (data_id_reg[7:4] == 4'h1);
        case (kind)
            KIND_TTX:               nat_len = LEN_TTX;
            KIND_VPS, KIND_VPS_F2:  nat_len = LEN_VPS;
            KIND_CPR:               nat_len = LEN_CPR;
            default:                nat_len = LEN_SHORT;
        endcase
        unit_len   = fixed_len ? LEN_FIXED : nat_len;
        f2         = (kind == KIND_CC525 || kind == KIND_CPR) ? FIELD2_525 : FIELD2_625;
        f2_diff    = line - f2;
        in_f1      = (line < 10'd32);
        in_f2      = (line >= f2) && (f2_diff[9:5] == 5'd0);
        enabled    = (kind != KIND_NONE) && svc_en_reg[kind];
        left_after = bytes_left_reg - {10'd0, unit_len};
    end

    // Configuration writes, state and evaluation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_id_reg    <= DATA_ID_RESET;
            svc_en_reg     <= SVC_EN_RESET;
            pkt_len_reg    <= PKT_LEN_RESET;
            bytes_left_reg <= PKT_LEN_RESET;
            prev_line_reg  <= 10'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DATA_ID: data_id_reg <= cfg_data[7:0];
                    REG_SVC_EN:  svc_en_reg  <= cfg_data[6:0];
                    REG_PKT_LEN: pkt_len_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (cmd.eval)
            begin
                if (item_reg.mode)
                begin
                    prev_line_reg  <= 10'd0;
                    bytes_left_reg <= psize;
                end
                else if (line == 10'd0 || line >= prev_line_reg)
                begin
                    if (line != 10'd0)
                    begin
                        prev_line_reg <= line;
                    end
                    if (enabled)
                    begin
                        if ({10'd0, unit_len} > bytes_left_reg)
                        begin
                            bytes_left_reg <= psize;
                        end
                        else if ((in_f1 || in_f2) && !(kind == KIND_VPS_F2 && in_f1))
                        begin
                            bytes_left_reg <= (left_after == 16'd0) ? psize : left_after;
                        end
                    end
                end
            end
        end
    end

    // Captured request and per-item results; payload registers need no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.eval)
        begin
            run_reg    <= bytes_left_reg;
            len_reg    <= unit_len;
            nat_reg    <= nat_len;
            lofp_reg   <= in_f1 ? (8'hE0 + {3'd0, line[4:0]})
                                : (8'hC0 + {3'd0, f2_diff[4:0]});
            pend_reg   <= (left_after == 16'd0);
            idx_reg    <= 6'd0;
            if (item_reg.mode)
            begin
                single_reg <= 1'b1;
                stuff_reg  <= 1'b1;
                status_reg <= ST_FLUSHED;
            end
            else if (line != 10'd0 && line < prev_line_reg)
            begin
                single_reg <= 1'b1;
                stuff_reg  <= 1'b0;
                status_reg <= ST_UNSORTED;
            end
            else if (!enabled)
            begin
                single_reg <= 1'b1;
                stuff_reg  <= 1'b0;
                status_reg <= ST_DISABLED;
            end
            else if ({10'd0, unit_len} > bytes_left_reg)
            begin
                single_reg <= 1'b1;
                stuff_reg  <= 1'b1;
                status_reg <= ST_FULL;
            end
            else if (!(in_f1 || in_f2))
            begin
                single_reg <= 1'b1;
                stuff_reg  <= 1'b0;
                status_reg <= ST_RANGE;
            end
            else if (kind == KIND_VPS_F2 && in_f1)
            begin
                single_reg <= 1'b1;
                stuff_reg  <= 1'b0;
                status_reg <= ST_VPS_AMB;
            end
            else
            begin
                single_reg <= 1'b0;
                stuff_reg  <= 1'b0;
                status_reg <= ST_PACKED;
            end
        end
        else if (cmd.load)
        begin
            idx_reg <= idx_reg + 6'd1;
        end
    end

    // Unit byte at the current index
    always_comb
    begin
        pay_flat = {item_reg.payload_5, item_reg.payload_4, item_reg.payload_3,
                    item_reg.payload_2, item_reg.payload_1, item_reg.payload_0};
        pay_idx  = (kind == KIND_TTX) ? (idx_reg - 6'd4) : (idx_reg - 6'd3);
        pay_byte = (pay_idx < 6'(PAY_BYTES)) ? rev8(pay_flat[{pay_idx, 3'b000} +: 8]) : 8'd0;
        if (idx_reg >= nat_reg)
        begin
            unit_byte = STUFF_BYTE;
        end
        else if (idx_reg == 6'd0)
        begin
            case (kind)
                KIND_TTX:               unit_byte = UID_TTX;
                KIND_VPS, KIND_VPS_F2:  unit_byte = UID_VPS;
                KIND_WSS:               unit_byte = UID_WSS;
                KIND_CC625:             unit_byte = UID_CC625;
                KIND_CC525:             unit_byte = UID_CC525;
                default:                unit_byte = UID_CPR;
            endcase
        end
        else if (idx_reg == 6'd1)
        begin
            unit_byte = {2'd0, nat_reg - 6'd2};
        end
        else if (idx_reg == 6'd2)
        begin
            unit_byte = lofp_reg;
        end
        else if (kind == KIND_TTX && idx_reg == 6'd3)
        begin
            unit_byte = TTX_FRAMING;
        end
        else if (kind == KIND_WSS && idx_reg == 6'd4)
        begin
            unit_byte = pay_byte | 8'h03;
        end
        else if (kind == KIND_CPR && idx_reg == 6'd5)
        begin
            unit_byte = pay_byte | 8'h0F;
        end
        else
        begin
            unit_byte = pay_byte;
        end
    end

    // Result assembly
    always_comb
    begin
        res_last = single_reg || (idx_reg == len_reg - 6'd1);
        if (single_reg)
        begin
            res.has_byte     = stuff_reg;
            res.out_byte     = stuff_reg ? STUFF_BYTE : 8'd0;
            res.stuffing_run = stuff_reg ? run_reg : 16'd0;
            res.packet_end   = stuff_reg;
        end
        else
        begin
            res.has_byte     = 1'b1;
            res.out_byte     = unit_byte;
            res.stuffing_run = 16'd0;
            res.packet_end   = res_last && pend_reg;
        end
        res.status = status_reg;
        res.last   = res_last;
        stat.out_free = !out_valid_reg || !out_stall;
        stat.res_last = res_last;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/vbi_sliced_data_unit_packer_tb.sv =====
// Self-checking testbench for the VBI sliced data unit packer.
// Depends on vbipk_pkg and vbi_sliced_data_unit_packer; predicts every output request.
module vbi_sliced_data_unit_packer_tb
    import vbipk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed
    localparam logic [1:0] REG_NONE  = 2'd3;

    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_LINES   = 60;
    localparam int RANDOM_PHASES = 7;

    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_req_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_req_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Lines waiting to be offered, and results the packer still owes
    in_req_t  lines_to_send[$];
    out_req_t unit_bytes_due[$];

    // Predictor copy of the registers and state
    logic [7:0]  data_id    = DATA_ID_RESET;
    logic [6:0]  svc_enable = SVC_EN_RESET;
    logic [15:0] pkt_len    = PKT_LEN_RESET;
    logic [15:0] bytes_free = PKT_LEN_RESET;
    logic [9:0]  prev_line  = '0;

    int       error_count = 0;
    int       results_checked = 0;
    int       lines_accepted = 0;
    int       settings_used = 1;
    int       send_gap = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    bit       quiet = 1'b0;
    int       gen_prev = 0;
    out_req_t want;

    vbi_sliced_data_unit_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Safety net against a hung handshake
    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic logic [7:0] flip_bits(input logic [7:0] v);
        logic [7:0] r;
        foreach (r[k])
        begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

    function automatic void push_result(input logic has, input logic [7:0] b,
                                        input logic [15:0] run, input logic [2:0] st,
                                        input logic pend, input logic fin);
        out_req_t r;
        r.has_byte     = has;
        r.out_byte     = b;
        r.stuffing_run = run;
        r.status       = st;
        r.packet_end   = pend;
        r.last         = fin;
        unit_bytes_due.push_back(r);
    endfunction

    function automatic void reload_packet();
        bytes_free = (pkt_len == 16'd0) ? 16'd1 : pkt_len;
    endfunction

    // Stuff the rest of the packet with one run and start a new one
    function automatic void stuff_packet(input logic [2:0] st);
        push_result(1'b1, STUFF_BYTE, bytes_free, st, 1'b1, 1'b1);
        reload_packet();
    endfunction

    // Work out the results of one accepted request and advance the state
    function automatic void pack_line(input in_req_t it);
        logic [335:0] raw;
        logic [7:0]   unit_b [46];
        logic [7:0]   lofp;
        int           ln;
        int           f2;
        int           ulen;
        int           nat;
        int           i;

        raw = {it.payload_5, it.payload_4, it.payload_3,
               it.payload_2, it.payload_1, it.payload_0};
        ln = it.line_number;

        if (it.mode)
        begin
            prev_line = '0;
            stuff_packet(ST_FLUSHED);
            return;
        end

        // Lines must not descend within a frame; line zero is unknown and exempt
        if (ln > 0)
        begin
            if (ln < prev_line)
            begin
                push_result(1'b0, 8'h00, 16'd0, ST_UNSORTED, 1'b0, 1'b1);
                return;
            end
            prev_line = it.line_number;
        end

        if (it.service_kind == KIND_NONE || svc_enable[it.service_kind] == 1'b0)
        begin
            push_result(1'b0, 8'h00, 16'd0, ST_DISABLED, 1'b0, 1'b1);
            return;
        end

        f2 = (it.service_kind == KIND_CC525 || it.service_kind == KIND_CPR) ?
             int'(FIELD2_525) : int'(FIELD2_625);

        if (data_id >= 8'h10 && data_id <= 8'h1F)
            ulen = LEN_FIXED;
        else if (it.service_kind == KIND_TTX)
            ulen = LEN_TTX;
        else if (it.service_kind == KIND_VPS || it.service_kind == KIND_VPS_F2)
            ulen = LEN_VPS;
        else if (it.service_kind == KIND_CPR)
            ulen = LEN_CPR;
        else
            ulen = LEN_SHORT;

        // A unit never straddles two packets
        if (ulen > bytes_free)
        begin
            stuff_packet(ST_FULL);
            return;
        end

        if (ln < 32)
            lofp = 8'hE0 + 8'(ln);
        else if (ln >= f2 && ln < f2 + 32)
            lofp = 8'hC0 + 8'(ln - f2);
        else
        begin
            push_result(1'b0, 8'h00, 16'd0, ST_RANGE, 1'b0, 1'b1);
            return;
        end

        if (it.service_kind == KIND_VPS_F2 && ln < 32)
        begin
            push_result(1'b0, 8'h00, 16'd0, ST_VPS_AMB, 1'b0, 1'b1);
            return;
        end

        // Assemble the data unit
        unit_b[2] = lofp;
        case (it.service_kind)
            KIND_TTX:
            begin
                unit_b[0] = UID_TTX;
                unit_b[1] = 8'd44;
                unit_b[3] = TTX_FRAMING;
                for (i = 0; i < PAY_BYTES; i++)
                    unit_b[4 + i] = flip_bits(raw[i * 8 +: 8]);
            end
            KIND_VPS, KIND_VPS_F2:
            begin
                unit_b[0] = UID_VPS;
                unit_b[1] = 8'd14;
                for (i = 0; i < 13; i++)
                    unit_b[3 + i] = flip_bits(raw[i * 8 +: 8]);
            end
            KIND_WSS:
            begin
                unit_b[0] = UID_WSS;
                unit_b[1] = 8'd3;
                unit_b[3] = flip_bits(raw[7:0]);
                unit_b[4] = flip_bits(raw[15:8]) | 8'h03;
            end
            KIND_CC625, KIND_CC525:
            begin
                unit_b[0] = (it.service_kind == KIND_CC625) ? UID_CC625 : UID_CC525;
                unit_b[1] = 8'd3;
                unit_b[3] = flip_bits(raw[7:0]);
                unit_b[4] = flip_bits(raw[15:8]);
            end
            default:
            begin
                unit_b[0] = UID_CPR;
                unit_b[1] = 8'd4;
                unit_b[3] = flip_bits(raw[7:0]);
                unit_b[4] = flip_bits(raw[15:8]);
                unit_b[5] = flip_bits(raw[23:16]) | 8'h0F;
            end
        endcase

        // Pad up to the unit length in fixed-length mode
        nat = int'(unit_b[1]) + 2;
        for (i = nat; i < ulen; i++)
            unit_b[i] = STUFF_BYTE;

        bytes_free = bytes_free - 16'(ulen);
        for (i = 0; i < ulen; i++)
        begin
            push_result(1'b1, unit_b[i], 16'd0, ST_PACKED,
                        (i == ulen - 1) && (bytes_free == 16'd0), i == ulen - 1);
        end
        if (bytes_free == 16'd0)
            reload_packet();
    endfunction

    function automatic in_req_t line_req(input logic [2:0] kind, input int line,
                                         input fill_t fill);
        in_req_t it;
        it = '0;
        it.service_kind = kind;
        it.line_number  = 10'(line);
        if (fill == FILL_ONES)
        begin
            {it.payload_5, it.payload_4, it.payload_3,
             it.payload_2, it.payload_1, it.payload_0} = '1;
        end
        else if (fill == FILL_RAND)
        begin
            it.payload_0 = 56'({$urandom, $urandom});
            it.payload_1 = 56'({$urandom, $urandom});
            it.payload_2 = 56'({$urandom, $urandom});
            it.payload_3 = 56'({$urandom, $urandom});
            it.payload_4 = 56'({$urandom, $urandom});
            it.payload_5 = 56'({$urandom, $urandom});
        end
        return it;
    endfunction

    function automatic in_req_t flush_req();
        in_req_t it;
        it = line_req(KIND_TTX, 0, FILL_RAND);
        it.mode = 1'b1;
        return it;
    endfunction

    // Mostly ascending lines in legal ranges, some noise and some flushes
    function automatic in_req_t random_line();
        in_req_t    it;
        int         pick;
        int         f2;
        int         lo;
        int         line;
        logic [2:0] kind;

        pick = $urandom_range(0, 99);
        if (pick < 7)
        begin
            gen_prev = 0;
            return flush_req();
        end
        if (pick < 17)
        begin
            it = line_req(3'($urandom_range(0, 7)), $urandom_range(0, 1023), FILL_RAND);
            if (it.line_number > gen_prev)
                gen_prev = it.line_number;
            return it;
        end
        kind = 3'($urandom_range(0, 6));
        f2 = (kind == KIND_CC525 || kind == KIND_CPR) ? int'(FIELD2_525) : int'(FIELD2_625);
        line = 0;
        if (pick < 22)
            line = 0;
        else if (gen_prev < 31 && $urandom_range(0, 2) == 0)
        begin
            lo = (gen_prev < 1) ? 1 : gen_prev;
            line = $urandom_range(lo, 31);
        end
        else
        begin
            lo = (gen_prev < f2) ? f2 : gen_prev;
            if (lo > f2 + 31)
            begin
                gen_prev = 0;
                return flush_req();
            end
            line = $urandom_range(lo, f2 + 31);
        end
        if (line != 0)
            gen_prev = line;
        return line_req(kind, line, FILL_RAND);
    endfunction

    // Configuration write, mirrored into the predictor once taken
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DATA_ID: data_id    = value[7:0];
            REG_SVC_EN:  svc_enable = value[6:0];
            REG_PKT_LEN: pkt_len    = value;
            default:     ;
        endcase
    endtask

    // Wait until every line is taken and every result has come back
    task automatic wait_drained();
        while (lines_to_send.size() != 0 || in_valid || unit_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // Line driver: offers queued requests, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
            lines_accepted <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pack_line(in_data);
                lines_accepted <= lines_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else if (lines_to_send.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= lines_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, so that the packer backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && lines_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left != 0)
            out_stall <= 1'b1;
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor: compare each accepted request with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (unit_bytes_due.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_checked));
            else
            begin
                want = unit_bytes_due.pop_front();
                if (out_data.has_byte !== want.has_byte)
                    report_mismatch($sformatf("result %0d has_byte %0b, expected %0b",
                        results_checked, out_data.has_byte, want.has_byte));
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("result %0d out_byte %h, expected %h",
                        results_checked, out_data.out_byte, want.out_byte));
                if (out_data.stuffing_run !== want.stuffing_run)
                    report_mismatch($sformatf("result %0d stuffing_run %0d, expected %0d",
                        results_checked, out_data.stuffing_run, want.stuffing_run));
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                        results_checked, out_data.status, want.status));
                if (out_data.packet_end !== want.packet_end)
                    report_mismatch($sformatf("result %0d packet_end %0b, expected %0b",
                        results_checked, out_data.packet_end, want.packet_end));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("result %0d last %0b, expected %0b",
                        results_checked, out_data.last, want.last));
            end
            results_checked++;
        end
    end

    // Stimulus sequence
    initial
    begin
        int ph;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: fixed 46-byte units, four to a packet
        lines_to_send.push_back(line_req(KIND_TTX, 7, FILL_ONES));
        lines_to_send.push_back(line_req(KIND_VPS, 16, FILL_ZERO));
        lines_to_send.push_back(line_req(KIND_WSS, 23, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_CC625, 313, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_CC525, 263, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_CPR, 0, FILL_ONES));
        lines_to_send.push_back(line_req(KIND_VPS_F2, 320, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_VPS_F2, 0, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_NONE, 330, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_TTX, 344, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_WSS, 345, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_TTX, 1023, FILL_ONES));
        lines_to_send.push_back(flush_req());
        lines_to_send.push_back(line_req(KIND_CC525, 294, FILL_ONES));
        lines_to_send.push_back(line_req(KIND_CPR, 1023, FILL_RAND));
        lines_to_send.push_back(flush_req());
        wait_drained();

        // Natural unit lengths, a small packet and some services off
        write_reg(REG_DATA_ID, 16'h0000);
        write_reg(REG_SVC_EN, 16'h005B);
        write_reg(REG_PKT_LEN, 16'd20);
        write_reg(REG_NONE, 16'($urandom));
        settings_used++;
        lines_to_send.push_back(flush_req());
        lines_to_send.push_back(line_req(KIND_WSS, 23, FILL_ONES));
        lines_to_send.push_back(line_req(KIND_CPR, 24, FILL_ONES));
        lines_to_send.push_back(line_req(KIND_VPS, 25, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_CC525, 26, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_VPS, 27, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_VPS_F2, 330, FILL_RAND));
        lines_to_send.push_back(line_req(KIND_TTX, 900, FILL_RAND));
        lines_to_send.push_back(flush_req());
        wait_drained();

        // Random lines under a series of register settings
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_DATA_ID, 16'h001F);
                    write_reg(REG_SVC_EN, 16'h007F);
                    write_reg(REG_PKT_LEN, 16'hFFFF);
                end
                1:
                begin
                    write_reg(REG_DATA_ID, 16'h0000);
                    write_reg(REG_PKT_LEN, 16'd184);
                end
                2:
                begin
                    write_reg(REG_DATA_ID, 16'h00FF);
                    write_reg(REG_SVC_EN, 16'h0000);
                    write_reg(REG_PKT_LEN, 16'd1);
                end
                3:
                begin
                    write_reg(REG_DATA_ID, 16'($urandom_range(0, 255)));
                    write_reg(REG_SVC_EN, 16'($urandom_range(0, 127)));
                    write_reg(REG_PKT_LEN, 16'd0);
                end
                4:
                begin
                    write_reg(REG_DATA_ID, 16'h0020);
                    write_reg(REG_SVC_EN, 16'h007F);
                    write_reg(REG_PKT_LEN, 16'($urandom_range(5, 100)));
                end
                5:
                begin
                    write_reg(REG_DATA_ID, 16'h0010);
                    write_reg(REG_SVC_EN, 16'($urandom_range(0, 127)));
                    write_reg(REG_PKT_LEN, 16'($urandom_range(46, 300)));
                end
                default:
                begin
                    write_reg(REG_DATA_ID, 16'h0000);
                    write_reg(REG_SVC_EN, 16'h007F);
                    write_reg(REG_PKT_LEN, 16'd47);
                    quiet = 1'b1;
                end
            endcase
            settings_used++;
            repeat (PHASE_LINES) lines_to_send.push_back(random_line());
            wait_drained();
        end

        // Let any stray result show itself
        repeat (60) @(posedge clk);
        if (unit_bytes_due.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      unit_bytes_due.size()));

        $display("Packed or skipped %0d lines and flushes under %0d register settings,",
                 lines_accepted, settings_used);
        $display("checking %0d output requests, %0d of them wrong.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
